@@ rtl/vnacc_pkg.sv @@
// package for the vertex normal accumulator
// command and status codes, default sizes and the controller/datapath interface types
// no dependencies
package vnacc_pkg;

    localparam int MAX_VERTICES_DEF         = 4096;
    localparam int MAX_BORDER_VERTICES_DEF  = 256;
    localparam int MAX_TRIANGLES_DEF        = 8192;
    localparam int MAX_BORDER_TRIANGLES_DEF = 512;

    localparam int IN_DATA_W  = 152;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_ADD     = 3'd2,
        CMD_COMPUTE = 3'd3,
        CMD_READ    = 3'd4
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } status_e_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_EXEC,
        OP_SWEEP,
        OP_WALK_INIT,
        OP_NEXT_PART,
        OP_TRI_RD,
        OP_FETCH,
        OP_EDGE,
        OP_SHIFT,
        OP_MUL,
        OP_NLOAD,
        OP_SQ,
        OP_ZERO_STAT,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_END,
        OP_SUM_RD,
        OP_SUM_WR,
        OP_TRI_NEXT,
        OP_RSUM_RD,
        OP_RSUM_LD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
        logic [1:0] comp;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       read_ok;
        logic       lanes_big;
        logic       sum_zero;
        logic       sweep_last;
        logic       tri_avail;
        logic       part_border;
        logic       corner_neg;
    } dp_stat_t;

endpackage

@@ rtl/vnacc_ctrl.sv @@
// controller state machine for the vertex normal accumulator
// sequences the datapath through clear, write, add, compute and read
// depends on vnacc_pkg
module vnacc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                out_free,
    output logic                res_load,
    output vnacc_pkg::dp_cmd_t  cmd,
    input  vnacc_pkg::dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_RST_SWEEP,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_WALK_INIT,
        S_WALK,
        S_TRI_RD,
        S_FETCH,
        S_EDGE,
        S_RED,
        S_MUL,
        S_NLOAD,
        S_SQ,
        S_ZCHK,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_SUM_RD,
        S_SUM_WR,
        S_TRI_NEXT,
        S_RSUM_RD,
        S_RSUM_LD,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] comp_reg, comp_next;
    logic       red_sel_reg, red_sel_next;
    logic       is_read;

    assign is_read  = (stat.kind == vnacc_pkg::CMD_READ);
    assign s_ready  = (state_reg == S_IDLE);
    assign res_load = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        comp_next    = comp_reg;
        red_sel_next = red_sel_reg;
        cmd.op       = vnacc_pkg::OP_NONE;
        cmd.step     = step_reg;
        cmd.comp     = comp_reg;
        case (state_reg)
            S_RST_SWEEP:
            begin
                cmd.op = vnacc_pkg::OP_SWEEP;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.op     = vnacc_pkg::OP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.op = vnacc_pkg::OP_EXEC;
                case (stat.kind)
                    vnacc_pkg::CMD_CLEAR:   state_next = S_SWEEP;
                    vnacc_pkg::CMD_COMPUTE: state_next = S_SWEEP;
                    vnacc_pkg::CMD_READ:    state_next = stat.read_ok ? S_RSUM_RD : S_DONE;
                    default:                state_next = S_DONE;
                endcase
            end
            S_SWEEP:
            begin
                cmd.op = vnacc_pkg::OP_SWEEP;
                if (stat.sweep_last)
                    state_next = (stat.kind == vnacc_pkg::CMD_COMPUTE) ? S_WALK_INIT : S_DONE;
            end
            S_WALK_INIT:
            begin
                cmd.op     = vnacc_pkg::OP_WALK_INIT;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.tri_avail)
                    state_next = S_TRI_RD;
                else if (!stat.part_border)
                    cmd.op = vnacc_pkg::OP_NEXT_PART;
                else
                    state_next = S_DONE;
            end
            S_TRI_RD:
            begin
                cmd.op     = vnacc_pkg::OP_TRI_RD;
                step_next  = 5'd0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.op = vnacc_pkg::OP_FETCH;
                if (step_reg == 5'd3)
                    state_next = S_EDGE;
                else
                    step_next = step_reg + 5'd1;
            end
            S_EDGE:
            begin
                cmd.op       = vnacc_pkg::OP_EDGE;
                red_sel_next = 1'b0;
                state_next   = S_RED;
            end
            S_RED:
            begin
                if (stat.lanes_big)
                    cmd.op = vnacc_pkg::OP_SHIFT;
                else
                begin
                    step_next  = 5'd0;
                    state_next = red_sel_reg ? S_SQ : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op = vnacc_pkg::OP_MUL;
                if (step_reg == 5'd6)
                    state_next = S_NLOAD;
                else
                    step_next = step_reg + 5'd1;
            end
            S_NLOAD:
            begin
                cmd.op       = vnacc_pkg::OP_NLOAD;
                red_sel_next = 1'b1;
                state_next   = S_RED;
            end
            S_SQ:
            begin
                cmd.op = vnacc_pkg::OP_SQ;
                if (step_reg == 5'd3)
                    state_next = S_ZCHK;
                else
                    step_next = step_reg + 5'd1;
            end
            S_ZCHK:
            begin
                if (stat.sum_zero)
                begin
                    if (is_read)
                    begin
                        cmd.op     = vnacc_pkg::OP_ZERO_STAT;
                        state_next = S_DONE;
                    end
                    else
                        // degenerate triangle adds nothing
                        state_next = S_TRI_NEXT;
                end
                else
                begin
                    cmd.op     = vnacc_pkg::OP_SQRT_INIT;
                    step_next  = 5'd0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op = vnacc_pkg::OP_SQRT;
                if (step_reg == 5'd31)
                begin
                    comp_next  = 2'd0;
                    state_next = S_DIV_INIT;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            S_DIV_INIT:
            begin
                cmd.op     = vnacc_pkg::OP_DIV_INIT;
                step_next  = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = vnacc_pkg::OP_DIV;
                if (step_reg == 5'd14)
                    state_next = S_DIV_END;
                else
                    step_next = step_reg + 5'd1;
            end
            S_DIV_END:
            begin
                cmd.op = vnacc_pkg::OP_DIV_END;
                if (comp_reg == 2'd2)
                begin
                    step_next  = 5'd0;
                    state_next = is_read ? S_DONE : S_SUM_RD;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_SUM_RD:
            begin
                if (stat.corner_neg)
                begin
                    // border corners keep no sum
                    if (step_reg == 5'd2)
                        state_next = S_TRI_NEXT;
                    else
                        step_next = step_reg + 5'd1;
                end
                else
                begin
                    cmd.op     = vnacc_pkg::OP_SUM_RD;
                    state_next = S_SUM_WR;
                end
            end
            S_SUM_WR:
            begin
                cmd.op = vnacc_pkg::OP_SUM_WR;
                if (step_reg == 5'd2)
                    state_next = S_TRI_NEXT;
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = S_SUM_RD;
                end
            end
            S_TRI_NEXT:
            begin
                cmd.op     = vnacc_pkg::OP_TRI_NEXT;
                state_next = S_WALK;
            end
            S_RSUM_RD:
            begin
                cmd.op     = vnacc_pkg::OP_RSUM_RD;
                state_next = S_RSUM_LD;
            end
            S_RSUM_LD:
            begin
                cmd.op       = vnacc_pkg::OP_RSUM_LD;
                red_sel_next = 1'b1;
                state_next   = S_RED;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_RST_SWEEP;
            step_reg    <= 5'd0;
            comp_reg    <= 2'd0;
            red_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            comp_reg    <= comp_next;
            red_sel_reg <= red_sel_next;
        end
    end

endmodule

@@ rtl/vnacc_dp.sv @@
// datapath for the vertex normal accumulator
// position, triangle and sum memories, shared multiplier, square root and divider
// depends on vnacc_pkg
module vnacc_dp #(
    parameter int MAX_VERTICES         = vnacc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_BORDER_VERTICES  = vnacc_pkg::MAX_BORDER_VERTICES_DEF,
    parameter int MAX_TRIANGLES        = vnacc_pkg::MAX_TRIANGLES_DEF,
    parameter int MAX_BORDER_TRIANGLES = vnacc_pkg::MAX_BORDER_TRIANGLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vnacc_pkg::dp_cmd_t                  cmd,
    output vnacc_pkg::dp_stat_t                 stat,
    input  logic [vnacc_pkg::IN_DATA_W-1:0]     in_data,
    input  logic [vnacc_pkg::IN_USER_W-1:0]     in_user,
    output logic [vnacc_pkg::OUT_DATA_W-1:0]    res_data,
    output logic [vnacc_pkg::OUT_USER_W-1:0]    res_user
);

    localparam int VA  = $clog2(MAX_VERTICES);
    localparam int BA  = $clog2(MAX_BORDER_VERTICES);
    localparam int TA  = $clog2(MAX_TRIANGLES);
    localparam int TBA = $clog2(MAX_BORDER_TRIANGLES);
    localparam int TC  = $clog2(MAX_TRIANGLES + 1);
    localparam int TBC = $clog2(MAX_BORDER_TRIANGLES + 1);
    localparam int WI  = (TC > TBC) ? TC : TBC;

    localparam logic [2:0] MUL_A [6] = '{3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd1};
    localparam logic [2:0] MUL_B [6] = '{3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3};

    function automatic logic [VA-1:0] main_addr(input logic [12:0] v);
        logic [31:0] w;
        w = {19'b0, v};
        return w[VA-1:0];
    endfunction

    function automatic logic [BA-1:0] border_addr(input logic [12:0] v);
        logic [31:0] w;
        w = {20'b0, ~v[11:0]};
        return w[BA-1:0];
    endfunction

    function automatic logic idx_ok(input logic [12:0] v);
        logic ok;
        if (v[12])
            ok = ({20'b0, ~v[11:0]} < 32'(MAX_BORDER_VERTICES));
        else
            ok = ({19'b0, v} < 32'(MAX_VERTICES));
        return ok;
    endfunction

    function automatic logic [19:0] sat_add(input logic [19:0] s, input logic [15:0] q);
        logic [20:0] t;
        logic [19:0] r;
        t = {s[19], s} + {{5{q[15]}}, q};
        if (t[20] != t[19])
            r = t[20] ? 20'h80000 : 20'h7FFFF;
        else
            r = t[19:0];
        return r;
    endfunction

    // memories
    logic [31:0] mpx_mem [MAX_VERTICES];
    logic [31:0] mpy_mem [MAX_VERTICES];
    logic [31:0] mpz_mem [MAX_VERTICES];
    logic [31:0] bpx_mem [MAX_BORDER_VERTICES];
    logic [31:0] bpy_mem [MAX_BORDER_VERTICES];
    logic [31:0] bpz_mem [MAX_BORDER_VERTICES];
    logic [38:0] mtri_mem [MAX_TRIANGLES];
    logic [38:0] btri_mem [MAX_BORDER_TRIANGLES];
    logic [59:0] sum_mem [MAX_VERTICES];

    // control registers
    logic [VA-1:0]  sweep_addr_reg;
    logic [TC-1:0]  mcnt_reg;
    logic [TBC-1:0] bcnt_reg;
    logic [WI-1:0]  tri_idx_reg;
    logic           part_reg;

    // payload registers
    logic [2:0]  it_cmd_reg;
    logic [12:0] it_vi_reg, it_a_reg, it_b_reg, it_c_reg;
    logic [31:0] it_px_reg, it_py_reg, it_pz_reg;
    logic [12:0] t_reg [3];
    logic [31:0] rm_reg [3];
    logic [31:0] rb_reg [3];
    logic        rneg_reg;
    logic [31:0] pa_reg [3];
    logic [31:0] pb_reg [3];
    logic [31:0] pc_reg [3];
    logic [61:0] mag_reg [6];
    logic        sgn_reg [6];
    logic signed [61:0] prod_reg;
    logic signed [63:0] n_reg [3];
    logic [63:0] ssq_reg;
    logic [63:0] sx_reg, sr_reg, sb_reg;
    logic [45:0] dn_reg, ds_reg;
    logic [14:0] quo_reg;
    logic [15:0] q_reg [3];
    logic [59:0] sum_rd_reg;
    logic [15:0] res_q_reg [3];
    logic [1:0]  res_status_reg;

    logic signed [30:0] lane_val [6];
    logic signed [30:0] mul_a, mul_b;
    logic        tri_ok, tri_border, mfull, bfull, add_m, add_b, vi_ok, read_ok;
    logic [63:0] sq_try;
    logic [2:0]  mk;
    logic [2:0]  lane_sel;
    logic [12:0] step_corner;

    assign vi_ok      = idx_ok(it_vi_reg);
    assign read_ok    = !it_vi_reg[12] && ({19'b0, it_vi_reg} < 32'(MAX_VERTICES));
    assign tri_ok     = idx_ok(it_a_reg) && idx_ok(it_b_reg) && idx_ok(it_c_reg);
    assign tri_border = it_a_reg[12] | it_b_reg[12] | it_c_reg[12];
    assign mfull      = 32'(mcnt_reg) >= 32'(MAX_TRIANGLES);
    assign bfull      = 32'(bcnt_reg) >= 32'(MAX_BORDER_TRIANGLES);
    assign add_m      = tri_ok && !tri_border && !mfull;
    assign add_b      = tri_ok && tri_border && !bfull;
    assign sq_try     = sr_reg + sb_reg;
    assign mk         = cmd.step[2:0] - 3'd1;
    assign lane_sel   = {1'b0, cmd.comp};

    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    step_corner = t_reg[0];
            2'd1:    step_corner = t_reg[1];
            default: step_corner = t_reg[2];
        endcase
    end

    always_comb
    begin
        stat.kind        = it_cmd_reg;
        stat.read_ok     = read_ok;
        stat.lanes_big   = 1'b0;
        for (int k = 0; k < 6; k++)
            stat.lanes_big = stat.lanes_big | (|mag_reg[k][61:30]);
        stat.sum_zero    = (ssq_reg == 64'd0);
        stat.sweep_last  = (32'(sweep_addr_reg) == 32'(MAX_VERTICES - 1));
        stat.tri_avail   = part_reg ? (32'(tri_idx_reg) < 32'(bcnt_reg))
                                    : (32'(tri_idx_reg) < 32'(mcnt_reg));
        stat.part_border = part_reg;
        stat.corner_neg  = step_corner[12];
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            lane_val[k] = sgn_reg[k] ? -$signed({1'b0, mag_reg[k][29:0]})
                                     : $signed({1'b0, mag_reg[k][29:0]});
    end

    // one shared multiplier for the cross product and the sum of squares
    always_comb
    begin
        mul_a = lane_val[{1'b0, cmd.step[1:0]}];
        mul_b = $signed({1'b0, mag_reg[{1'b0, cmd.step[1:0]}][29:0]});
        if (cmd.op == vnacc_pkg::OP_MUL && cmd.step < 5'd6)
        begin
            mul_a = lane_val[MUL_A[cmd.step[2:0]]];
            mul_b = lane_val[MUL_B[cmd.step[2:0]]];
        end
        else if (cmd.op == vnacc_pkg::OP_SQ)
            mul_a = $signed({1'b0, mag_reg[{1'b0, cmd.step[1:0]}][29:0]});
    end

    assign res_data = {res_q_reg[2], res_q_reg[1], res_q_reg[0]};
    assign res_user = res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
            mcnt_reg       <= '0;
            bcnt_reg       <= '0;
            tri_idx_reg    <= '0;
            part_reg       <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                vnacc_pkg::OP_SWEEP:
                begin
                    if (32'(sweep_addr_reg) == 32'(MAX_VERTICES - 1))
                        sweep_addr_reg <= '0;
                    else
                        sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
                vnacc_pkg::OP_EXEC:
                begin
                    if (it_cmd_reg == vnacc_pkg::CMD_CLEAR)
                    begin
                        mcnt_reg <= '0;
                        bcnt_reg <= '0;
                    end
                    else if (it_cmd_reg == vnacc_pkg::CMD_ADD)
                    begin
                        if (add_m)
                            mcnt_reg <= mcnt_reg + 1'b1;
                        if (add_b)
                            bcnt_reg <= bcnt_reg + 1'b1;
                    end
                end
                vnacc_pkg::OP_WALK_INIT:
                begin
                    tri_idx_reg <= '0;
                    part_reg    <= 1'b0;
                end
                vnacc_pkg::OP_NEXT_PART:
                begin
                    tri_idx_reg <= '0;
                    part_reg    <= 1'b1;
                end
                vnacc_pkg::OP_TRI_NEXT:
                begin
                    tri_idx_reg <= tri_idx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            vnacc_pkg::OP_LOAD:
            begin
                it_cmd_reg     <= in_user;
                it_vi_reg      <= in_data[12:0];
                it_px_reg      <= in_data[44:13];
                it_py_reg      <= in_data[76:45];
                it_pz_reg      <= in_data[108:77];
                it_a_reg       <= in_data[121:109];
                it_b_reg       <= in_data[134:122];
                it_c_reg       <= in_data[147:135];
                res_status_reg <= vnacc_pkg::ST_OK;
                for (int k = 0; k < 3; k++)
                    res_q_reg[k] <= 16'd0;
            end
            vnacc_pkg::OP_EXEC:
            begin
                case (it_cmd_reg)
                    vnacc_pkg::CMD_WRITE:
                    begin
                        if (!vi_ok)
                            res_status_reg <= vnacc_pkg::ST_RANGE;
                        else if (it_vi_reg[12])
                        begin
                            bpx_mem[border_addr(it_vi_reg)] <= it_px_reg;
                            bpy_mem[border_addr(it_vi_reg)] <= it_py_reg;
                            bpz_mem[border_addr(it_vi_reg)] <= it_pz_reg;
                        end
                        else
                        begin
                            mpx_mem[main_addr(it_vi_reg)] <= it_px_reg;
                            mpy_mem[main_addr(it_vi_reg)] <= it_py_reg;
                            mpz_mem[main_addr(it_vi_reg)] <= it_pz_reg;
                        end
                    end
                    vnacc_pkg::CMD_ADD:
                    begin
                        if (!tri_ok)
                            res_status_reg <= vnacc_pkg::ST_RANGE;
                        else if (tri_border ? bfull : mfull)
                            res_status_reg <= vnacc_pkg::ST_FULL;
                        if (add_m)
                            mtri_mem[mcnt_reg[TA-1:0]] <= {it_c_reg, it_b_reg, it_a_reg};
                        if (add_b)
                            btri_mem[bcnt_reg[TBA-1:0]] <= {it_c_reg, it_b_reg, it_a_reg};
                    end
                    vnacc_pkg::CMD_READ:
                    begin
                        if (!read_ok)
                            res_status_reg <= vnacc_pkg::ST_RANGE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            vnacc_pkg::OP_SWEEP:
            begin
                sum_mem[sweep_addr_reg] <= 60'd0;
            end
            vnacc_pkg::OP_TRI_RD:
            begin
                if (part_reg)
                    {t_reg[2], t_reg[1], t_reg[0]} <= btri_mem[tri_idx_reg[TBA-1:0]];
                else
                    {t_reg[2], t_reg[1], t_reg[0]} <= mtri_mem[tri_idx_reg[TA-1:0]];
            end
            vnacc_pkg::OP_FETCH:
            begin
                // read one corner and place the one read in the cycle before
                if (cmd.step < 5'd3)
                begin
                    rm_reg[0] <= mpx_mem[main_addr(step_corner)];
                    rm_reg[1] <= mpy_mem[main_addr(step_corner)];
                    rm_reg[2] <= mpz_mem[main_addr(step_corner)];
                    rb_reg[0] <= bpx_mem[border_addr(step_corner)];
                    rb_reg[1] <= bpy_mem[border_addr(step_corner)];
                    rb_reg[2] <= bpz_mem[border_addr(step_corner)];
                    rneg_reg  <= step_corner[12];
                end
                for (int k = 0; k < 3; k++)
                begin
                    case (cmd.step)
                        5'd1:    pa_reg[k] <= rneg_reg ? rb_reg[k] : rm_reg[k];
                        5'd2:    pb_reg[k] <= rneg_reg ? rb_reg[k] : rm_reg[k];
                        5'd3:    pc_reg[k] <= rneg_reg ? rb_reg[k] : rm_reg[k];
                        default: ;
                    endcase
                end
            end
            vnacc_pkg::OP_EDGE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [32:0] d1, d2;
                    d1 = {pb_reg[k][31], pb_reg[k]} - {pa_reg[k][31], pa_reg[k]};
                    d2 = {pc_reg[k][31], pc_reg[k]} - {pa_reg[k][31], pa_reg[k]};
                    sgn_reg[k]     <= d1[32];
                    mag_reg[k]     <= {29'b0, (d1[32] ? -d1 : d1)};
                    sgn_reg[k + 3] <= d2[32];
                    mag_reg[k + 3] <= {29'b0, (d2[32] ? -d2 : d2)};
                end
            end
            vnacc_pkg::OP_SHIFT:
            begin
                for (int k = 0; k < 6; k++)
                    mag_reg[k] <= mag_reg[k] >> 1;
            end
            vnacc_pkg::OP_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                if (cmd.step != 5'd0)
                begin
                    if (mk[0])
                        n_reg[mk[2:1]] <= n_reg[mk[2:1]] - 64'(prod_reg);
                    else
                        n_reg[mk[2:1]] <= 64'(prod_reg);
                end
            end
            vnacc_pkg::OP_NLOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [63:0] a;
                    a = n_reg[k][63] ? -n_reg[k] : n_reg[k];
                    sgn_reg[k]     <= n_reg[k][63];
                    mag_reg[k]     <= a[61:0];
                    sgn_reg[k + 3] <= 1'b0;
                    mag_reg[k + 3] <= 62'd0;
                end
            end
            vnacc_pkg::OP_SQ:
            begin
                prod_reg <= mul_a * mul_b;
                if (cmd.step == 5'd0)
                    ssq_reg <= 64'd0;
                else
                    ssq_reg <= ssq_reg + 64'(prod_reg);
            end
            vnacc_pkg::OP_ZERO_STAT:
            begin
                res_status_reg <= vnacc_pkg::ST_ZERO;
            end
            vnacc_pkg::OP_SQRT_INIT:
            begin
                sx_reg <= ssq_reg;
                sr_reg <= 64'd0;
                sb_reg <= 64'd1 << 62;
            end
            vnacc_pkg::OP_SQRT:
            begin
                if (sx_reg >= sq_try)
                begin
                    sx_reg <= sx_reg - sq_try;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sb_reg <= sb_reg >> 2;
            end
            vnacc_pkg::OP_DIV_INIT:
            begin
                dn_reg  <= {2'b0, mag_reg[lane_sel][29:0], 14'b0} + 46'(sr_reg >> 1);
                ds_reg  <= {sr_reg[31:0], 14'b0};
                quo_reg <= 15'd0;
            end
            vnacc_pkg::OP_DIV:
            begin
                if (dn_reg >= ds_reg)
                begin
                    dn_reg  <= dn_reg - ds_reg;
                    quo_reg <= {quo_reg[13:0], 1'b1};
                end
                else
                    quo_reg <= {quo_reg[13:0], 1'b0};
                ds_reg <= ds_reg >> 1;
            end
            vnacc_pkg::OP_DIV_END:
            begin
                logic [15:0] qv;
                qv = sgn_reg[lane_sel] ? -{1'b0, quo_reg} : {1'b0, quo_reg};
                q_reg[cmd.comp] <= qv;
                if (it_cmd_reg == vnacc_pkg::CMD_READ)
                    res_q_reg[cmd.comp] <= qv;
            end
            vnacc_pkg::OP_SUM_RD:
            begin
                sum_rd_reg <= sum_mem[main_addr(step_corner)];
            end
            vnacc_pkg::OP_SUM_WR:
            begin
                sum_mem[main_addr(step_corner)] <= {sat_add(sum_rd_reg[59:40], q_reg[2]),
                                                    sat_add(sum_rd_reg[39:20], q_reg[1]),
                                                    sat_add(sum_rd_reg[19:0], q_reg[0])};
            end
            vnacc_pkg::OP_RSUM_RD:
            begin
                sum_rd_reg <= sum_mem[main_addr(it_vi_reg)];
            end
            vnacc_pkg::OP_RSUM_LD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [19:0] s;
                    s = sum_rd_reg[20*k +: 20];
                    sgn_reg[k]     <= s[19];
                    mag_reg[k]     <= {42'b0, (s[19] ? -s : s)};
                    sgn_reg[k + 3] <= 1'b0;
                    mag_reg[k + 3] <= 62'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/vertex_normal_accumulator_unit.sv @@
// top level of the vertex normal accumulator
// controller, datapath and the output register; depends on vnacc_pkg, vnacc_ctrl, vnacc_dp
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: vertex_index, pos_x, pos_y, pos_z, corners
//  m_axis   | out       | tdata: normal_x, normal_y, normal_z; tuser: status
//
// one item at a time, one result per item; the controller steps the datapath memories,
// one shared multiplier, a square root of one step per cycle and a divider of one bit
// per cycle. compute first clears the sums and then works through every stored triangle.
// after reset a clearing pass over the sums runs before the first transfer is taken.
// the next item is taken while a result waits in the output register.
module vertex_normal_accumulator_unit #(
    parameter int MAX_VERTICES         = vnacc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_BORDER_VERTICES  = vnacc_pkg::MAX_BORDER_VERTICES_DEF,
    parameter int MAX_TRIANGLES        = vnacc_pkg::MAX_TRIANGLES_DEF,
    parameter int MAX_BORDER_TRIANGLES = vnacc_pkg::MAX_BORDER_TRIANGLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // vertex_index[12:0], pos_x[44:13], pos_y[76:45], pos_z[108:77],
    // corner_a[121:109], corner_b[134:122], corner_c[147:135], zero fill
    input  logic [vnacc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [vnacc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32]
    output logic [vnacc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [vnacc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    vnacc_pkg::dp_cmd_t  cmd;
    vnacc_pkg::dp_stat_t stat;
    logic                out_free, res_load;
    logic [vnacc_pkg::OUT_DATA_W-1:0] res_data;
    logic [vnacc_pkg::OUT_USER_W-1:0] res_user;
    logic                             m_valid_reg;
    logic [vnacc_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [vnacc_pkg::OUT_USER_W-1:0] m_user_reg;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    vnacc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .out_free (out_free),
        .res_load (res_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    vnacc_dp #(
        .MAX_VERTICES         (MAX_VERTICES),
        .MAX_BORDER_VERTICES  (MAX_BORDER_VERTICES),
        .MAX_TRIANGLES        (MAX_TRIANGLES),
        .MAX_BORDER_TRIANGLES (MAX_BORDER_TRIANGLES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .res_data (res_data),
        .res_user (res_user)
    );

    // output register: holds a finished transfer while the next item is worked on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (res_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_data_reg <= res_data;
            m_user_reg <= res_user;
        end
    end

endmodule
